// ===== hdl/awp_pkg.sv =====
// Shared types, constants and codes of the analysis window planner.
package awp_pkg;

	// Field widths
	localparam int FREQ_W  = 40;
	localparam int RATE_W  = 40;
	localparam int PER_W   = 16;
	localparam int CNT_W   = 20;
	localparam int PHASE_W = 32;
	localparam int CMD_W   = 2;

	// Product rate * periods
	localparam int PROD_W = RATE_W + PER_W;

	// Shared divider: widest dividend is freq << 32, widest divisor is 2 * freq
	localparam int DIV_NUM_W = FREQ_W + PHASE_W;
	localparam int DIV_DEN_W = FREQ_W + 1;

	// Default capture buffer length in samples
	localparam int BUFFER_SAMPLES_DEF = 524288;

	// Register reset values
	localparam logic [RATE_W-1:0] RATE_RESET    = 40'd1000000000000;
	localparam logic [PER_W-1:0]  PERIODS_RESET = 16'd1;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	typedef enum logic {
		REG_RATE    = 1'b0,
		REG_PERIODS = 1'b1
	} reg_index_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PLAN    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_NOP     = 2'd3
	} command_t;

	typedef struct packed {
		command_t            command;
		logic [FREQ_W-1:0]   freq_uhz;
	} in_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]   used_samples;
		logic [PHASE_W-1:0] phase_step;
		logic [CNT_W-1:0]   segment_count;
		logic [CNT_W-1:0]   overlap;
		logic [CNT_W-1:0]   spread_remainder;
		logic [CNT_W-1:0]   position;
	} out_word_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [PER_W-1:0]  periods;
	} cfg_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_MUL,
		OP_DIV_LEN,
		OP_STORE_LEN,
		OP_DIV_PHASE,
		OP_STORE_PHASE,
		OP_DIV_CNT,
		OP_STORE_CNT,
		OP_DIV_OV,
		OP_STORE_OV,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		command_t cmd;       // command of the word at the input
		logic     div_busy;  // shared divider is running
		logic     len_ok;    // divider quotient is a usable window length
		logic     exact;     // divider remainder is zero
		logic     out_free;  // output register can take a word
	} dp_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LEN_GO,
		S_LEN_WAIT,
		S_PH_GO,
		S_PH_WAIT,
		S_CNT_GO,
		S_CNT_WAIT,
		S_OV_GO,
		S_OV_WAIT,
		S_EMIT
	} ctrl_state_t;

endpackage

// ===== hdl/analysis_window_planner.sv =====
// Top level of the analysis window planner: register port, controller and datapath.
//
//  Channel  Signals                                     Word
//  -------  ------------------------------------------  -------------------------------
//  in       in_valid, in_ready, in_data                 command, freq_uhz
//  out      out_valid, out_ready, out_data              plan values and window position
//  cfg      psel, penable, pwrite, paddr, pwdata,       sample_rate_uhz at 0x0,
//           prdata, pready                              periods at 0x8
//
//  Restart, advance and no-action words are accepted and applied, then loaded into the output register.
//  A plan word stops after the length pass when the window length is unusable, skips the
//  overlap pass when the buffer divides evenly and otherwise runs all four shared divider passes.
//  in_ready stays low from the accept until the word is loaded into the output register;
//  a stalled output holds the block in its last step.
//  Reset clears all plan and position state and loads the register defaults.
module analysis_window_planner #(
	parameter int BUFFER_SAMPLES = awp_pkg::BUFFER_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input words
	input  logic                          in_valid,
	output logic                          in_ready,
	input  awp_pkg::in_word_t             in_data,
	// Result words
	output logic                          out_valid,
	input  logic                          out_ready,
	output awp_pkg::out_word_t            out_data,
	// Register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [awp_pkg::PADDR_W-1:0]   paddr,
	input  logic [awp_pkg::PDATA_W-1:0]   pwdata,
	output logic [awp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	awp_pkg::cfg_t       cfg_q;
	awp_pkg::dp_cmd_t    dp_cmd;
	awp_pkg::dp_status_t dp_status;
	awp_pkg::reg_index_t reg_sel;
	logic                cfg_write;

	// Registers sit on 8-byte steps; bit 3 picks the register, low bits alias
	assign reg_sel   = awp_pkg::reg_index_t'(paddr[3]);
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	// Write the addressed register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate    <= awp_pkg::RATE_RESET;
			cfg_q.periods <= awp_pkg::PERIODS_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				awp_pkg::REG_RATE:    cfg_q.rate    <= pwdata[awp_pkg::RATE_W-1:0];
				awp_pkg::REG_PERIODS: cfg_q.periods <= pwdata[awp_pkg::PER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register, zero-extended
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			awp_pkg::REG_RATE:    prdata = awp_pkg::PDATA_W'(cfg_q.rate);
			awp_pkg::REG_PERIODS: prdata = awp_pkg::PDATA_W'(cfg_q.periods);
			default: prdata = '0;
		endcase
	end

	// Sequence each word: accept, plan divisions when asked, then emit
	awp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (dp_status),
		.in_ready (in_ready),
		.cmd      (dp_cmd)
	);

	// Hold the plan and position, run the divider, drive the output register
	awp_dp #(
		.BUFFER_SAMPLES (BUFFER_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_word   (in_data),
		.cmd       (dp_cmd),
		.out_ready (out_ready),
		.status    (dp_status),
		.out_valid (out_valid),
		.out_word  (out_data)
	);

endmodule

// ===== hdl/awp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module awp_div #(
	parameter int NUM_W = awp_pkg::DIV_NUM_W,
	parameter int DEN_W = awp_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic [NUM_W-1:0] quotient,
	output logic [DEN_W-1:0] remainder
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	// Bring down the next dividend bit and try the subtraction
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(NUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/awp_dp.sv =====
// Datapath: plan state, window position, shared divider and output register.
module awp_dp #(
	parameter int BUFFER_SAMPLES = awp_pkg::BUFFER_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  awp_pkg::cfg_t       cfg,
	input  awp_pkg::in_word_t   in_word,
	input  awp_pkg::dp_cmd_t    cmd,
	input  logic                out_ready,
	output awp_pkg::dp_status_t status,
	output logic                out_valid,
	output awp_pkg::out_word_t  out_word
);

	localparam int BUF_W     = $clog2(BUFFER_SAMPLES + 1);
	localparam int LEN_MAX   = (1 << awp_pkg::CNT_W) - 1;
	localparam int LEN_LIMIT = (BUFFER_SAMPLES < LEN_MAX) ? BUFFER_SAMPLES : LEN_MAX;
	localparam int SUM_W     = ((BUF_W > awp_pkg::CNT_W) ? BUF_W : awp_pkg::CNT_W) + 1;
	localparam int NUM_W     = awp_pkg::DIV_NUM_W;
	localparam int DEN_W     = awp_pkg::DIV_DEN_W;
	localparam int C_W       = awp_pkg::CNT_W;

	// Plan state
	logic [C_W-1:0]                window_len_q;
	logic [awp_pkg::PHASE_W-1:0]   phase_incr_q;
	logic [BUF_W-1:0]              window_total_q;
	logic [C_W-1:0]                overlap_len_q;
	logic [BUF_W-1:0]              overlap_rem_q;
	// Position state
	logic [C_W-1:0]                start_pos_q;
	logic [C_W-1:0]                frac_sum_q;
	// Plan scratch
	logic [awp_pkg::FREQ_W-1:0]    freq_q;
	logic [awp_pkg::PROD_W-1:0]    prod_q;
	logic [BUF_W-1:0]              cnt_q;
	logic [C_W-1:0]                diff_q;
	// Output register
	logic                          out_valid_q;
	awp_pkg::out_word_t            out_q;

	// Divider hookup
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_busy;
	logic [NUM_W-1:0] div_quo;
	logic [DEN_W-1:0] div_rem;

	// Advance arithmetic
	logic [SUM_W-1:0] adv_sum;
	logic             adv_wrap;
	logic [C_W-1:0]   adv_pos;
	logic [C_W-1:0]   adv_frac;
	logic             len_ok;
	logic             out_free;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			awp_pkg::OP_DIV_LEN: begin
				div_start = 1'b1;
				div_num   = NUM_W'({prod_q, 1'b0}) + NUM_W'(freq_q);
				div_den   = {freq_q, 1'b0};
			end
			awp_pkg::OP_DIV_PHASE: begin
				div_start = 1'b1;
				div_num   = {freq_q, {awp_pkg::PHASE_W{1'b0}}};
				div_den   = DEN_W'(cfg.rate);
			end
			awp_pkg::OP_DIV_CNT: begin
				div_start = 1'b1;
				div_num   = NUM_W'(BUFFER_SAMPLES);
				div_den   = DEN_W'(window_len_q);
			end
			awp_pkg::OP_DIV_OV: begin
				div_start = 1'b1;
				div_num   = NUM_W'(diff_q);
				div_den   = DEN_W'(cnt_q);
			end
			default: begin
			end
		endcase
	end

	awp_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Step forward by len - overlap, one back whenever the spread carries
	assign adv_sum  = SUM_W'(frac_sum_q) + SUM_W'(overlap_rem_q);
	assign adv_wrap = adv_sum >= SUM_W'(window_total_q);
	assign adv_pos  = start_pos_q + (window_len_q - overlap_len_q) - C_W'(adv_wrap);
	assign adv_frac = adv_wrap ? C_W'(adv_sum - SUM_W'(window_total_q)) : C_W'(adv_sum);

	assign len_ok   = (div_quo != '0) && (div_quo <= NUM_W'(LEN_LIMIT)) && (cfg.rate != '0);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q   <= '0;
			phase_incr_q   <= '0;
			window_total_q <= '0;
			overlap_len_q  <= '0;
			overlap_rem_q  <= '0;
			start_pos_q    <= '0;
			frac_sum_q     <= '0;
		end else begin
			case (cmd.op)
				awp_pkg::OP_ACCEPT: begin
					case (in_word.command)
						awp_pkg::CMD_RESTART: begin
							start_pos_q <= '0;
							frac_sum_q  <= C_W'(overlap_rem_q);
						end
						awp_pkg::CMD_ADVANCE: begin
							if (window_len_q != '0) begin
								start_pos_q <= adv_pos;
								frac_sum_q  <= adv_frac;
							end
						end
						default: begin
						end
					endcase
				end
				awp_pkg::OP_STORE_LEN: begin
					if (len_ok) begin
						window_len_q <= C_W'(div_quo);
					end else begin
						window_len_q   <= '0;
						phase_incr_q   <= '0;
						window_total_q <= '0;
						overlap_len_q  <= '0;
						overlap_rem_q  <= '0;
					end
				end
				awp_pkg::OP_STORE_PHASE: begin
					phase_incr_q <= div_quo[awp_pkg::PHASE_W-1:0];
				end
				awp_pkg::OP_STORE_CNT: begin
					if (div_rem == '0) begin
						window_total_q <= BUF_W'(div_quo);
						overlap_len_q  <= '0;
						overlap_rem_q  <= '0;
					end else begin
						window_total_q <= BUF_W'(div_quo) + 1'b1;
					end
				end
				awp_pkg::OP_STORE_OV: begin
					overlap_len_q <= C_W'(div_quo);
					overlap_rem_q <= BUF_W'(div_rem);
				end
				default: begin
				end
			endcase
		end
	end

	// Plan scratch registers
	always_ff @(posedge clk) begin
		if (cmd.op == awp_pkg::OP_ACCEPT) begin
			freq_q <= in_word.freq_uhz;
		end
		if (cmd.op == awp_pkg::OP_MUL) begin
			prod_q <= cfg.rate * cfg.periods;
		end
		if (cmd.op == awp_pkg::OP_STORE_CNT) begin
			cnt_q  <= BUF_W'(div_quo);
			diff_q <= window_len_q - C_W'(div_rem);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == awp_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == awp_pkg::OP_EMIT) begin
			out_q.used_samples     <= window_len_q;
			out_q.phase_step       <= phase_incr_q;
			out_q.segment_count    <= C_W'(window_total_q);
			out_q.overlap          <= overlap_len_q;
			out_q.spread_remainder <= C_W'(overlap_rem_q);
			out_q.position         <= start_pos_q;
		end
	end

	assign status.cmd      = in_word.command;
	assign status.div_busy = div_busy;
	assign status.len_ok   = len_ok;
	assign status.exact    = (div_rem == '0);
	assign status.out_free = out_free;
	assign out_valid       = out_valid_q;
	assign out_word        = out_q;

	// A zero window always comes with an all-zero plan
	a_zero_plan: assert property (@(posedge clk) disable iff (!arst_n)
		(window_len_q == '0) |-> (phase_incr_q == '0) && (window_total_q == '0) &&
		(overlap_len_q == '0) && (overlap_rem_q == '0))
		else $error("zero window with leftover plan values");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while running");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == awp_pkg::OP_EMIT) |-> out_free)
		else $error("output word overwritten before it was taken");

endmodule

// ===== hdl/awp_ctrl.sv =====
// Controller state machine: sequences accept, plan divisions and output.
module awp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  awp_pkg::dp_status_t status,
	output logic                in_ready,
	output awp_pkg::dp_cmd_t    cmd
);

	awp_pkg::ctrl_state_t state_q;
	awp_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= awp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			awp_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (status.cmd == awp_pkg::CMD_PLAN) ? awp_pkg::S_MUL : awp_pkg::S_EMIT;
				end
			end
			awp_pkg::S_MUL:    state_d = awp_pkg::S_LEN_GO;
			awp_pkg::S_LEN_GO: state_d = awp_pkg::S_LEN_WAIT;
			awp_pkg::S_LEN_WAIT: begin
				if (!status.div_busy) begin
					state_d = status.len_ok ? awp_pkg::S_PH_GO : awp_pkg::S_EMIT;
				end
			end
			awp_pkg::S_PH_GO: state_d = awp_pkg::S_PH_WAIT;
			awp_pkg::S_PH_WAIT: begin
				if (!status.div_busy) begin
					state_d = awp_pkg::S_CNT_GO;
				end
			end
			awp_pkg::S_CNT_GO: state_d = awp_pkg::S_CNT_WAIT;
			awp_pkg::S_CNT_WAIT: begin
				if (!status.div_busy) begin
					state_d = status.exact ? awp_pkg::S_EMIT : awp_pkg::S_OV_GO;
				end
			end
			awp_pkg::S_OV_GO: state_d = awp_pkg::S_OV_WAIT;
			awp_pkg::S_OV_WAIT: begin
				if (!status.div_busy) begin
					state_d = awp_pkg::S_EMIT;
				end
			end
			awp_pkg::S_EMIT: begin
				if (status.out_free) begin
					state_d = awp_pkg::S_IDLE;
				end
			end
			default: state_d = awp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = awp_pkg::OP_NONE;
		unique case (state_q)
			awp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = awp_pkg::OP_ACCEPT;
				end
			end
			awp_pkg::S_MUL:    cmd.op = awp_pkg::OP_MUL;
			awp_pkg::S_LEN_GO: cmd.op = awp_pkg::OP_DIV_LEN;
			awp_pkg::S_LEN_WAIT: begin
				if (!status.div_busy) begin
					cmd.op = awp_pkg::OP_STORE_LEN;
				end
			end
			awp_pkg::S_PH_GO: cmd.op = awp_pkg::OP_DIV_PHASE;
			awp_pkg::S_PH_WAIT: begin
				if (!status.div_busy) begin
					cmd.op = awp_pkg::OP_STORE_PHASE;
				end
			end
			awp_pkg::S_CNT_GO: cmd.op = awp_pkg::OP_DIV_CNT;
			awp_pkg::S_CNT_WAIT: begin
				if (!status.div_busy) begin
					cmd.op = awp_pkg::OP_STORE_CNT;
				end
			end
			awp_pkg::S_OV_GO: cmd.op = awp_pkg::OP_DIV_OV;
			awp_pkg::S_OV_WAIT: begin
				if (!status.div_busy) begin
					cmd.op = awp_pkg::OP_STORE_OV;
				end
			end
			awp_pkg::S_EMIT: begin
				if (status.out_free) begin
					cmd.op = awp_pkg::OP_EMIT;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/tb_analysis_window_planner.sv =====
// Self-checking testbench of the analysis window planner: random and directed words, scoreboard.
module tb_analysis_window_planner;
	timeunit 1ns;
	timeprecision 1ps;

	import awp_pkg::*;

	localparam int BUF_LEN = BUFFER_SAMPLES_DEF;
	localparam int ITEMS_PER_PHASE = 85;
	// Long receiver hold-off; far longer than a restart or advance, so the block backs up
	localparam int LONG_HOLD = 500;
	// Upper bound on the run length; once it is reached the bench stops and reports failure
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam logic [PER_W-1:0] PER_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// Words waiting to be offered, and result words the planner must still return
	in_word_t cmd_backlog[$];
	out_word_t planned_words[$];

	// Shadow copy of the registers and of the planner state
	logic [RATE_W-1:0] rate_cfg = RATE_RESET;
	logic [PER_W-1:0] per_cfg = PERIODS_RESET;
	logic [31:0] win_len = '0;
	logic [31:0] phase_acc = '0;
	logic [31:0] win_count = '0;
	logic [31:0] ov_len = '0;
	logic [31:0] ov_rem = '0;
	logic [31:0] start_at = '0;
	logic [31:0] frac_acc = '0;

	int mismatches = 0;
	int cycles = 0;
	bit idle_off = 1'b0;
	int hold_requests = 0;
	int holds_done = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned hold_left = 0;
	out_word_t want;

	analysis_window_planner #(
		.BUFFER_SAMPLES(BUF_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Hard stop in case the planner hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly back-to-back, sometimes a short pause, rarely a long one; never a pause while idle_off is set
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (idle_off || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Recompute the window plan for frequency f with the current registers.
	// A window of zero length, or one that does not fit the buffer, clears the plan.
	function automatic void plan_windows(logic [FREQ_W-1:0] f);
		logic [63:0] num;
		logic [63:0] len;
		logic [63:0] cnt;
		logic [63:0] gap;
		logic [63:0] ov;
		logic [71:0] ph;
		len = '0;
		if (f != '0) begin
			// round(rate * periods / f) with halves up
			num = 64'd2 * 64'(rate_cfg) * 64'(per_cfg) + 64'(f);
			len = num / (64'(f) << 1);
			if (len > 64'(BUF_LEN) || len > 64'hFFFFF)
				len = '0;
		end
		if (len == '0 || rate_cfg == '0) begin
			win_len = '0;
			phase_acc = '0;
			win_count = '0;
			ov_len = '0;
			ov_rem = '0;
			return;
		end
		win_len = 32'(len);
		// Full-width phase step, keep the low 32 bits only
		ph = {f, 32'd0} / 72'(rate_cfg);
		phase_acc = ph[31:0];
		cnt = 64'(BUF_LEN) / len;
		if (len * cnt != 64'(BUF_LEN)) begin
			// One more window than fits; spread the excess as overlap
			cnt = cnt + 1;
			gap = len * cnt - 64'(BUF_LEN);
			ov = gap / (cnt - 1);
			ov_len = 32'(ov);
			ov_rem = 32'(gap - ov * (cnt - 1));
		end else begin
			ov_len = '0;
			ov_rem = '0;
		end
		win_count = 32'(cnt);
	endfunction

	// Apply one command word to the shadow state and return the word the planner must emit
	function automatic out_word_t window_plan_step(in_word_t w);
		out_word_t r;
		logic [31:0] pos;
		logic [31:0] sum;
		case (w.command)
			CMD_PLAN: begin
				plan_windows(w.freq_uhz);
			end
			CMD_RESTART: begin
				start_at = '0;
				frac_acc = ov_rem & 32'hFFFFF;
			end
			CMD_ADVANCE: begin
				// Bresenham step: pull back one sample whenever the remainder wraps
				if (win_len != '0) begin
					pos = start_at + (win_len - ov_len);
					sum = frac_acc + ov_rem;
					if (sum >= win_count) begin
						pos = pos - 1;
						sum = sum - win_count;
					end
					start_at = pos & 32'hFFFFF;
					frac_acc = sum & 32'hFFFFF;
				end
			end
			default: ;
		endcase
		r.used_samples = win_len[CNT_W-1:0];
		r.phase_step = phase_acc;
		r.segment_count = win_count[CNT_W-1:0];
		r.overlap = ov_len[CNT_W-1:0];
		r.spread_remainder = ov_rem[CNT_W-1:0];
		r.position = start_at[CNT_W-1:0];
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// Sender: hold each word until accepted, predict its result on the accepting edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			tx_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				planned_words.push_back(window_plan_step(in_data));
			if (!in_valid || in_ready) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (cmd_backlog.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= cmd_backlog.pop_front();
					tx_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result word against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap <= 0;
			hold_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (planned_words.size() == 0) begin
					$error("result word with no prediction pending");
					mismatches++;
				end else begin
					want = planned_words.pop_front();
					compare_field("used_samples", 32'(want.used_samples), 32'(out_data.used_samples));
					compare_field("phase_step", want.phase_step, out_data.phase_step);
					compare_field("segment_count", 32'(want.segment_count),
						32'(out_data.segment_count));
					compare_field("overlap", 32'(want.overlap), 32'(out_data.overlap));
					compare_field("spread_remainder", 32'(want.spread_remainder),
						32'(out_data.spread_remainder));
					compare_field("position", 32'(want.position), 32'(out_data.position));
				end
			end
			if (holds_done < hold_requests) begin
				// Hold off long enough for the block to fill and drop in_ready
				hold_left <= LONG_HOLD;
				holds_done <= holds_done + 1;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap <= rx_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_gap <= pick_gap();
			end
		end
	end

	function automatic logic [FREQ_W-1:0] rand40();
		return {8'($urandom), 32'($urandom)};
	endfunction

	// Mostly frequencies aimed at a usable window length for the current registers
	function automatic logic [FREQ_W-1:0] pick_freq();
		logic [63:0] prod;
		logic [63:0] f;
		int unsigned pick;
		int unsigned target;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return '0;
		if (pick < 8)
			return FREQ_MAX;
		if (pick < 25)
			return rand40();
		target = (pick < 65) ? $urandom_range(1, 4096) : $urandom_range(4097, 530000);
		prod = 64'(rate_cfg) * 64'(per_cfg);
		f = prod / 64'(target) + 64'($urandom_range(0, 1));
		if (f > 64'(FREQ_MAX))
			f = 64'(FREQ_MAX);
		return f[FREQ_W-1:0];
	endfunction

	task automatic queue_word(command_t c, logic [FREQ_W-1:0] f);
		in_word_t w;
		w.command = c;
		w.freq_uhz = f;
		cmd_backlog.push_back(w);
	endtask

	// Mostly plan / restart / advance runs with random content, the rest loose words
	task automatic queue_random_items(int count);
		int made;
		int k;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 9) < 7) begin
				queue_word(CMD_PLAN, pick_freq());
				queue_word(CMD_RESTART, rand40());
				k = $urandom_range(1, 8);
				repeat (k)
					queue_word(($urandom_range(0, 9) == 0) ? CMD_NOP : CMD_ADVANCE, rand40());
				made += k + 2;
			end else begin
				queue_word(command_t'($urandom_range(0, 3)), pick_freq());
				made++;
			end
		end
	endtask

	// Block until every word is sent and every result is back
	task automatic wait_for_drain();
		@(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || planned_words.size() != 0)
			@(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle; the write lands at the access edge
	task automatic write_reg(reg_index_t idx, logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(int'(idx) * 8);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_RATE)
			rate_cfg = val[RATE_W-1:0];
		else
			per_cfg = val[PER_W-1:0];
	endtask

	task automatic run_phase(logic [RATE_W-1:0] rate, logic [PER_W-1:0] per, bit calm, bit hold);
		// Let the last plan settle before touching the registers
		repeat (4) @(posedge clk);
		write_reg(REG_RATE, PDATA_W'(rate));
		write_reg(REG_PERIODS, PDATA_W'(per));
		@(negedge clk);
		idle_off = calm;
		queue_random_items(ITEMS_PER_PHASE);
		if (hold)
			hold_requests++;
		wait_for_drain();
	endtask

	initial begin
		logic [RATE_W-1:0] some_rate;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset registers (1 MHz rate, one period)
		queue_word(CMD_ADVANCE, FREQ_MAX);     // advance with no plan: no change
		queue_word(CMD_NOP, '0);               // no action: report state
		queue_word(CMD_RESTART, '0);
		queue_word(CMD_PLAN, '0);              // zero frequency clears the plan
		queue_word(CMD_PLAN, FREQ_MAX);        // one-sample window, buffer divides exactly
		queue_word(CMD_ADVANCE, '0);
		queue_word(CMD_ADVANCE, '0);
		queue_word(CMD_PLAN, 40'd976562500);   // 1024-sample window, no overlap
		queue_word(CMD_RESTART, '0);
		queue_word(CMD_ADVANCE, '0);
		queue_word(CMD_ADVANCE, '0);
		queue_word(CMD_PLAN, 40'd1000000000);  // 1000 samples: overlap with remainder
		queue_word(CMD_RESTART, '0);
		repeat (4)
			queue_word(CMD_ADVANCE, '0);
		queue_word(CMD_PLAN, 40'd400000000000); // 2.5 samples rounds up to 3
		queue_word(CMD_ADVANCE, '0);
		queue_word(CMD_PLAN, 40'd1);           // window far too long: clear
		queue_word(CMD_ADVANCE, '0);
		queue_word(CMD_PLAN, 40'd1907349);     // window equals the whole buffer
		queue_word(CMD_RESTART, '0);
		queue_word(CMD_ADVANCE, '0);
		queue_word(CMD_PLAN, 40'd1907346);     // one sample over the buffer: clear
		wait_for_drain();

		// Random phases across register settings, extremes included
		some_rate = {8'($urandom), 32'($urandom)};
		if (some_rate == '0)
			some_rate = 1;
		run_phase(RATE_MAX, PER_MAX, 1'b0, 1'b1);
		run_phase(40'd1, 16'd1, 1'b1, 1'b0);
		run_phase(40'd48000000000, 16'd8, 1'b0, 1'b0);
		run_phase(some_rate, 16'($urandom_range(1, 65535)), 1'b0, 1'b1);
		run_phase(40'd1, PER_MAX, 1'b0, 1'b0);
		run_phase(RATE_MAX, 16'd1, 1'b1, 1'b0);
		run_phase(RATE_RESET, PERIODS_RESET, 1'b0, 1'b0);

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
